FILE: rtl/lrb_pkg.sv
// ----------------------------------------------------------------------------
// lrb_pkg: shared types and constants for the light range bisection block
// Payload structs, register indexes, outcome codes and fixed-point widths.
// ----------------------------------------------------------------------------
package lrb_pkg;

  localparam int unsigned LEVEL_W  = 17;  // Q1.16 level, 65536 = 1.0
  localparam int unsigned DIST_W   = 24;  // Q16.8 distance
  localparam int unsigned COEF_W   = 24;  // Q8.16 coefficient
  localparam int unsigned ITER_W   = 7;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned OUTC_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  localparam int unsigned DEN_W    = 40;
  localparam int unsigned SUM_W    = 57;
  localparam int unsigned QUO_W    = 16;
  localparam int unsigned MUL_A_W  = 24;
  localparam int unsigned MUL_B_W  = 32;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;

  localparam int unsigned ITER_BOUND = 64;

  localparam logic [DEN_W-1:0]   DEN_MAX = {DEN_W{1'b1}};
  localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'd65536;

  // floor(x/10) = (x * 209716) >> 21 for every 17-bit x
  localparam logic [MUL_B_W-1:0] DIV10_MAGIC = 32'd209716;
  localparam int unsigned        DIV10_SHIFT = 21;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTEN_CONST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEN_LIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEN_QUAD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_DIST    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_THR    = 3'd5;

  // register reset values
  localparam logic [COEF_W-1:0] RST_ATTEN_CONST = 24'd0;
  localparam logic [COEF_W-1:0] RST_ATTEN_LIN   = 24'd65536;
  localparam logic [COEF_W-1:0] RST_ATTEN_QUAD  = 24'd0;
  localparam logic [DIST_W-1:0] RST_FAR_DIST    = 24'd2560000;
  localparam logic [ITER_W-1:0] RST_MAX_ITER    = 7'd32;
  localparam logic [THR_W-1:0]  RST_ZERO_THR    = 16'd7;

  // outcome codes
  localparam logic [OUTC_W-1:0] OUTC_FOUND      = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_TOO_BRIGHT = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_EXHAUSTED  = 2'd2;
  localparam logic [OUTC_W-1:0] OUTC_UNUSED     = 2'd3;

  typedef struct packed {
    logic [LEVEL_W-1:0] target_level;
    logic [LEVEL_W-1:0] accuracy;
  } lrb_req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [OUTC_W-1:0] outcome;
  } lrb_res_t;

  typedef struct packed {
    logic             start;
    logic [DEN_W-1:0] den;
  } lrb_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } lrb_div_rsp_t;

endpackage

FILE: rtl/light_range_bisection.sv
// ----------------------------------------------------------------------------
// light_range_bisection: point light reach search
// Finds the distance at which a light's brightness falls into a level band.
// ----------------------------------------------------------------------------
// Usage:
//   Write coefficients and limits through cfg_we_i/cfg_idx_i/cfg_data_i while
//   busy_o is low. Raise start_i with req_i (target level, accuracy); the
//   request is taken when start_i is high and busy_o is low. busy_o stays
//   high until the result beat: done_o is high for exactly one cycle with
//   res_o (distance, outcome), and busy_o drops in that same cycle so the
//   next request may be taken there. The receiver cannot stall the result.
// Sequence:
//   Setup states S_ADJ and S_BAND, then one brightness evaluation for the far
//   check and one per bisection step (up to max_iterations, capped at 64). An
//   evaluation runs through the shared multiplier in S_DD, S_QH, S_QL, S_LD
//   and S_SUM, then S_DEN, plus the bit-serial divider in S_DIV when the
//   reciprocal is needed; one request at a time.
// Reset:
//   rst_ni clears the sequencer and loads the register reset values; no
//   request is pending after reset.
// ----------------------------------------------------------------------------
module light_range_bisection (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  lrb_pkg::lrb_req_t               req_i,
  output logic                            busy_o,
  output logic                            done_o,
  output lrb_pkg::lrb_res_t               res_o,
  input  logic                            cfg_we_i,
  input  logic [lrb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lrb_pkg::CFG_DAT_W-1:0]   cfg_data_i
);
  import lrb_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_ADJ    = 11'b00000000010,
    S_BAND   = 11'b00000000100,
    S_DD     = 11'b00000001000,
    S_QH     = 11'b00000010000,
    S_QL     = 11'b00000100000,
    S_LD     = 11'b00001000000,
    S_SUM    = 11'b00010000000,
    S_DEN    = 11'b00100000000,
    S_DIV    = 11'b01000000000,
    S_DECIDE = 11'b10000000000
  } lrb_state_e;

  function automatic logic [DIST_W-1:0] midpoint(input logic [DIST_W-1:0] lo,
                                                 input logic [DIST_W-1:0] hi);
    return lo + ((hi - lo) >> 1);
  endfunction

  // configuration registers
  logic [COEF_W-1:0] c_q, l_q, q_q;
  logic [DIST_W-1:0] far_q;
  logic [ITER_W-1:0] max_it_q;
  logic [THR_W-1:0]  zthr_q;

  // sequencer and datapath
  lrb_state_e          state_q, state_d;
  logic [LEVEL_W-1:0]  tgt_q, tgt_d, acc_q, acc_d, acc_n;
  logic signed [LEVEL_W+1:0] band_lo_q, band_lo_d;
  logic [LEVEL_W:0]    band_hi_q, band_hi_d;
  logic                far_chk_q, far_chk_d;
  logic [DIST_W-1:0]   lo_q, lo_d, hi_q, hi_d, d_q, d_d, lo_n, hi_n;
  logic [ITER_W-1:0]   iter_q, iter_d, budget;
  logic [15:0]         ddlo_q, ddlo_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [LEVEL_W-1:0]  bright_q, bright_d;
  logic                done_q, done_d;
  lrb_res_t            res_q, res_d;
  logic [DEN_W-1:0]    den_sat, thresh;
  logic                too_dim, too_bright;

  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   prod;
  lrb_div_req_t        div_req;
  lrb_div_rsp_t        div_rsp;

  lrb_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  lrb_recip u_recip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign budget  = (max_it_q > ITER_W'(ITER_BOUND)) ? ITER_W'(ITER_BOUND) : max_it_q;
  assign den_sat = (sum_q > SUM_W'(DEN_MAX)) ? DEN_MAX : sum_q[DEN_W-1:0];
  assign thresh  = far_chk_q ? DEN_W'(acc_q) : DEN_W'(zthr_q);

  assign too_dim    = $signed({2'b00, bright_q}) < band_lo_q;
  assign too_bright = {1'b0, bright_q} > band_hi_q;

  always_comb begin
    state_d   = state_q;
    tgt_d     = tgt_q;
    acc_d     = acc_q;
    acc_n     = acc_q;
    band_lo_d = band_lo_q;
    band_hi_d = band_hi_q;
    far_chk_d = far_chk_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    lo_n      = lo_q;
    hi_n      = hi_q;
    d_d       = d_q;
    iter_d    = iter_q;
    ddlo_d    = ddlo_q;
    sum_d     = sum_q;
    bright_d  = bright_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mul_a     = '0;
    mul_b     = '0;
    div_req.start = 1'b0;
    div_req.den   = den_sat;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          tgt_d   = req_i.target_level;
          acc_d   = req_i.accuracy;
          state_d = S_ADJ;
        end
      end
      S_ADJ: begin
        mul_a   = MUL_A_W'(tgt_q);
        mul_b   = DIV10_MAGIC;
        state_d = S_BAND;
      end
      S_BAND: begin
        if (tgt_q != '0 && acc_q >= tgt_q) begin
          acc_n = prod[DIV10_SHIFT +: LEVEL_W];
        end
        acc_d     = acc_n;
        band_lo_d = $signed({2'b00, tgt_q}) - $signed({2'b00, acc_n});
        band_hi_d = {1'b0, tgt_q} + {1'b0, acc_n};
        d_d       = far_q;
        far_chk_d = 1'b1;
        state_d   = S_DD;
      end
      S_DD: begin
        mul_a   = d_q;
        mul_b   = MUL_B_W'(d_q);
        state_d = S_QH;
      end
      S_QH: begin
        mul_a   = q_q;
        mul_b   = prod[47:16];
        ddlo_d  = prod[15:0];
        state_d = S_QL;
      end
      S_QL: begin
        mul_a   = q_q;
        mul_b   = MUL_B_W'(ddlo_q);
        sum_d   = SUM_W'(prod);
        state_d = S_LD;
      end
      S_LD: begin
        mul_a   = l_q;
        mul_b   = MUL_B_W'(d_q);
        sum_d   = sum_q + SUM_W'(prod >> 16);
        state_d = S_SUM;
      end
      S_SUM: begin
        sum_d   = sum_q + SUM_W'(prod >> 8) + SUM_W'(c_q);
        state_d = S_DEN;
      end
      S_DEN: begin
        // at or below 2^16 the reciprocal clips to full brightness anyway
        if (den_sat <= thresh || den_sat <= DEN_W'(ONE_Q16)) begin
          bright_d = ONE_Q16;
          state_d  = S_DECIDE;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          bright_d = {1'b0, div_rsp.quo};
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (far_chk_q) begin
          far_chk_d = 1'b0;
          lo_d      = '0;
          hi_d      = far_q;
          iter_d    = '0;
          d_d       = midpoint('0, far_q);
          if (too_bright) begin
            res_d.distance = far_q;
            res_d.outcome  = OUTC_TOO_BRIGHT;
            done_d         = 1'b1;
            state_d        = S_IDLE;
          end else if (budget == '0) begin
            res_d.distance = midpoint('0, far_q);
            res_d.outcome  = OUTC_EXHAUSTED;
            done_d         = 1'b1;
            state_d        = S_IDLE;
          end else begin
            state_d = S_DD;
          end
        end else begin
          if (too_dim) begin
            hi_n = d_q;
          end else if (too_bright) begin
            lo_n = d_q;
          end
          lo_d   = lo_n;
          hi_d   = hi_n;
          iter_d = iter_q + 1'b1;
          d_d    = midpoint(lo_n, hi_n);
          if (!too_dim && !too_bright) begin
            res_d.distance = d_q;
            res_d.outcome  = OUTC_FOUND;
            done_d         = 1'b1;
            state_d        = S_IDLE;
          end else if (iter_q + 1'b1 == budget) begin
            res_d.distance = midpoint(lo_n, hi_n);
            res_d.outcome  = OUTC_EXHAUSTED;
            done_d         = 1'b1;
            state_d        = S_IDLE;
          end else begin
            state_d = S_DD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      far_chk_q <= 1'b0;
      iter_q    <= '0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      far_chk_q <= far_chk_d;
      iter_q    <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q     <= tgt_d;
    acc_q     <= acc_d;
    band_lo_q <= band_lo_d;
    band_hi_q <= band_hi_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    d_q       <= d_d;
    ddlo_q    <= ddlo_d;
    sum_q     <= sum_d;
    bright_q  <= bright_d;
    res_q     <= res_d;
  end

  // configuration writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q      <= RST_ATTEN_CONST;
      l_q      <= RST_ATTEN_LIN;
      q_q      <= RST_ATTEN_QUAD;
      far_q    <= RST_FAR_DIST;
      max_it_q <= RST_MAX_ITER;
      zthr_q   <= RST_ZERO_THR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ATTEN_CONST: c_q      <= cfg_data_i[COEF_W-1:0];
        REG_ATTEN_LIN:   l_q      <= cfg_data_i[COEF_W-1:0];
        REG_ATTEN_QUAD:  q_q      <= cfg_data_i[COEF_W-1:0];
        REG_FAR_DIST:    far_q    <= cfg_data_i[DIST_W-1:0];
        REG_MAX_ITER:    max_it_q <= cfg_data_i[ITER_W-1:0];
        REG_ZERO_THR:    zthr_q   <= cfg_data_i[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: rtl/lrb_mul.sv
// ----------------------------------------------------------------------------
// lrb_mul: shared unsigned multiplier
// One 24 x 32 product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module lrb_mul (
  input  logic                         clk_i,
  input  logic [lrb_pkg::MUL_A_W-1:0]  a_i,
  input  logic [lrb_pkg::MUL_B_W-1:0]  b_i,
  output logic [lrb_pkg::PROD_W-1:0]   prod_o
);
  import lrb_pkg::*;

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/lrb_recip.sv
// ----------------------------------------------------------------------------
// lrb_recip: iterative reciprocal
// Computes floor(2^32 / den) one quotient bit per cycle
// for a denominator above 2^16 so the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module lrb_recip (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lrb_pkg::lrb_div_req_t req_i,
  output lrb_pkg::lrb_div_rsp_t rsp_o
);
  import lrb_pkg::*;

  localparam int unsigned REM_W = 33;
  localparam int unsigned DSH_W = DEN_W + QUO_W - 1;
  localparam int unsigned CNT_W = $clog2(QUO_W);

  logic [REM_W-1:0] rem_q;
  logic [DSH_W-1:0] dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic             fits;

  assign fits = (dsh_q <= DSH_W'(rem_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= REM_W'(1) << 32;
      dsh_q <= {req_i.den, {(QUO_W-1){1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      // restoring step: subtract the shifted divisor where it fits
      if (fits) begin
        rem_q <= rem_q - dsh_q[REM_W-1:0];
      end
      quo_q <= {quo_q[QUO_W-2:0], fits};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

FILE: rtl/lrb_checker.sv
// ----------------------------------------------------------------------------
// lrb_checker: port-level checks for light_range_bisection
// Watches request, busy and result beats on the top-level ports.
// ----------------------------------------------------------------------------
module lrb_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_o,
  input  logic              done_o,
  input  lrb_pkg::lrb_res_t res_o
);
  import lrb_pkg::*;

  // a taken request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("request taken but block not busy");

  // a result beat closes a busy period
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $fell(busy_o))
    else $error("result beat without a preceding busy period");

  // every busy period ends with a result beat
  a_busy_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy period ended without a result beat");

  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.outcome != OUTC_UNUSED)
    else $error("result beat carries an unused outcome code");

endmodule

bind light_range_bisection lrb_checker u_lrb_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);
